### hw/rtl/rsbc_pkg.sv
`default_nettype none

package rsbc_pkg;

    // Fixed geometry of the digit histogram and the keys.
    localparam int KEY_W        = 32;
    localparam int CFG_W        = 3;
    localparam int PASS_W       = 2;
    localparam int DIGIT_W      = 8;
    localparam int DIGIT_VALUES = 256;
    localparam int HIST_IDX_W   = 9;
    localparam logic [DIGIT_W-1:0] DIGIT_MASK = 8'd255;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [PASS_W-1:0]  t_pass;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_COUNT   = 5'b00010,
        ST_PREFIX  = 5'b00100,
        ST_SCATTER = 5'b01000,
        ST_EMIT    = 5'b10000
    } t_state;

    // Access request to the histogram memory.
    typedef struct packed {
        logic   clear;
        logic   we;
        t_digit waddr;
        t_digit raddr;
    } t_hist_ctl;

    // Select the digit of a key that a given pass sorts on.
    function automatic t_digit digit_of(input t_key key, input t_pass pass);
        t_digit d;
        case (pass)
            2'd0:    d = key[7:0];
            2'd1:    d = key[15:8];
            2'd2:    d = key[23:16];
            2'd3:    d = key[31:24];
            default: d = key[7:0];
        endcase
        return d & DIGIT_MASK;
    endfunction

    // Index of the final pass; zero acts as one pass, values above four as four.
    function automatic t_pass last_pass(input logic [CFG_W-1:0] cfg);
        t_pass p;
        case (cfg)
            3'd0, 3'd1: p = 2'd0;
            3'd2:       p = 2'd1;
            3'd3:       p = 2'd2;
            default:    p = 2'd3;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rsbc_ram.sv
`default_nettype none

module rsbc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; a read of the entry being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/rsbc_hist.sv
`default_nettype none

module rsbc_hist #(
    parameter int CW = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rsbc_pkg::t_hist_ctl  i_ctl,
    input  wire logic [CW-1:0]        i_wdata,
    output logic      [CW-1:0]        o_rdata
);

    logic [CW-1:0]            ram_rdata;
    logic [rsbc_pkg::DIGIT_VALUES-1:0] r_vld;
    rsbc_pkg::t_digit         r_rd_addr;
    logic                     r_last_we;
    rsbc_pkg::t_digit         r_last_waddr;
    logic [CW-1:0]            r_last_wdata;

    rsbc_ram #(
        .DEPTH (rsbc_pkg::DIGIT_VALUES),
        .WIDTH (CW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_ctl.waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_ctl.raddr),
        .o_rdata (ram_rdata)
    );

    // Per-entry valid bits; clearing them empties the whole histogram at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_ctl.waddr] <= 1'b1;
        end
    end

    // Remember the last write so a read issued on the same edge sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_we <= 1'b0;
        end else begin
            r_last_we <= i_ctl.we && !i_ctl.clear;
        end
        r_rd_addr    <= i_ctl.raddr;
        r_last_waddr <= i_ctl.waddr;
        r_last_wdata <= i_wdata;
    end

    // Forwarded value first, then memory contents, and zero for a cleared entry.
    always_comb begin
        if (r_last_we && (r_last_waddr == r_rd_addr)) begin
            o_rdata = r_last_wdata;
        end else if (r_vld[r_rd_addr]) begin
            o_rdata = ram_rdata;
        end else begin
            o_rdata = '0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/radix_sort_byte_counting.sv
`default_nettype none

// Radix sorter for sets of 32-bit unsigned keys, 8-bit digits, LSD first.
// Input: a key item is accepted on a rising edge with start high and busy low.
// Keys load at one per cycle into a key buffer; the item with i_last_key set
// closes the set and starts the sort, and busy stays high until the last
// result has gone out. Keys beyond MAX_KEYS are dropped and o_overflow is set
// on every result of that set; a dropped last key still starts the sort.
// Configuration: i_cfg_we writes i_cfg_data as the pass count (1 to 4, reset 4;
// 0 acts as 1 and 5 to 7 as 4). Write it only while busy is low.
// Each pass runs a count sweep and a scatter sweep over the n keys at one key
// per cycle through the histogram read-modify-write pipeline, plus an offset
// sweep over the 256-entry histogram. Results then stream at one per cycle, each
// shown for one cycle with o_strobe; the receiver cannot stall. Reset returns to
// idle with an empty set and no clearing pass is needed.
module radix_sort_byte_counting #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rsbc_pkg::KEY_W-1:0]    i_key_value,
    input  wire logic                          i_last_key,
    input  wire logic                          i_cfg_we,
    input  wire logic [rsbc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                               o_strobe,
    output logic      [rsbc_pkg::KEY_W-1:0]    o_sorted_key,
    output logic                               o_last_result,
    output logic                               o_overflow
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int IW = $clog2(MAX_KEYS);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_KEYS);
    localparam logic [rsbc_pkg::HIST_IDX_W-1:0] HIST_END =
        rsbc_pkg::HIST_IDX_W'(rsbc_pkg::DIGIT_VALUES);

    rsbc_pkg::t_state  r_state, n_state;
    logic [rsbc_pkg::CFG_W-1:0] r_cfg_passes;
    logic [CW-1:0]     r_key_count;
    logic              r_overflow;
    logic              r_src_sel;
    rsbc_pkg::t_pass   r_pass;
    logic [CW-1:0]     r_idx;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic              r_s2_valid;
    rsbc_pkg::t_digit  r_s2_digit;
    rsbc_pkg::t_key    r_s2_key;
    logic [rsbc_pkg::HIST_IDX_W-1:0] r_hidx;
    logic              r_p1_valid;
    rsbc_pkg::t_digit  r_p1_addr;
    logic [CW-1:0]     r_offset;

    logic              accept;
    logic              store_key;
    logic              in_count;
    logic              in_prefix;
    logic              in_scatter;
    logic              in_emit;
    logic              issue_more;
    logic              key_issue;
    logic              drained;
    rsbc_pkg::t_key    key_rdata;
    rsbc_pkg::t_key    buf0_rdata;
    rsbc_pkg::t_key    buf1_rdata;
    rsbc_pkg::t_digit  s1_digit;
    rsbc_pkg::t_hist_ctl hist_ctl;
    logic [CW-1:0]     hist_wdata;
    logic [CW-1:0]     hist_val;
    logic              scat_we;
    logic [IW-1:0]     buf_waddr;
    rsbc_pkg::t_key    buf_wdata;
    logic              buf0_we;
    logic              buf1_we;

    // Phase decode and handshake.
    assign in_count   = (r_state == rsbc_pkg::ST_COUNT);
    assign in_prefix  = (r_state == rsbc_pkg::ST_PREFIX);
    assign in_scatter = (r_state == rsbc_pkg::ST_SCATTER);
    assign in_emit    = (r_state == rsbc_pkg::ST_EMIT);
    assign busy       = (r_state != rsbc_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign store_key  = accept && (r_key_count != FULL_COUNT);

    // Key sweeps issue one read per cycle until every stored key is read.
    assign issue_more = (r_idx != r_key_count);
    assign key_issue  = (in_count || in_scatter || in_emit) && issue_more;
    assign drained    = !issue_more && !r_s1_valid && !r_s2_valid;

    assign key_rdata = r_src_sel ? buf1_rdata : buf0_rdata;
    assign s1_digit  = rsbc_pkg::digit_of(key_rdata, r_pass);

    // Histogram access: offset sweep walks all entries, key sweeps use digits.
    always_comb begin
        hist_ctl.clear = (n_state == rsbc_pkg::ST_COUNT) && !in_count;
        hist_ctl.raddr = in_prefix ? r_hidx[rsbc_pkg::DIGIT_W-1:0] : s1_digit;
        hist_ctl.we    = in_prefix ? r_p1_valid : ((in_count || in_scatter) && r_s2_valid);
        hist_ctl.waddr = in_prefix ? r_p1_addr : r_s2_digit;
        hist_wdata     = in_prefix ? r_offset : (hist_val + CW'(1));
    end

    rsbc_hist #(
        .CW (CW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .i_wdata (hist_wdata),
        .o_rdata (hist_val)
    );

    // Key buffers: loads go to the source buffer, scatters to the other one.
    assign scat_we   = in_scatter && r_s2_valid;
    assign buf_waddr = in_scatter ? hist_val[IW-1:0] : r_key_count[IW-1:0];
    assign buf_wdata = in_scatter ? r_s2_key : i_key_value;
    assign buf0_we   = (store_key && !r_src_sel) || (scat_we && r_src_sel);
    assign buf1_we   = (store_key && r_src_sel) || (scat_we && !r_src_sel);

    rsbc_ram #(
        .DEPTH (MAX_KEYS),
        .WIDTH (rsbc_pkg::KEY_W)
    ) u_buf0 (
        .i_clk   (i_clk),
        .i_we    (buf0_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (buf0_rdata)
    );

    rsbc_ram #(
        .DEPTH (MAX_KEYS),
        .WIDTH (rsbc_pkg::KEY_W)
    ) u_buf1 (
        .i_clk   (i_clk),
        .i_we    (buf1_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (buf1_rdata)
    );

    // Sequencer: each phase ends once its pipeline has drained.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsbc_pkg::ST_IDLE: begin
                if (accept && i_last_key) begin
                    n_state = rsbc_pkg::ST_COUNT;
                end
            end
            rsbc_pkg::ST_COUNT: begin
                if (drained) begin
                    n_state = rsbc_pkg::ST_PREFIX;
                end
            end
            rsbc_pkg::ST_PREFIX: begin
                if ((r_hidx == HIST_END) && !r_p1_valid) begin
                    n_state = rsbc_pkg::ST_SCATTER;
                end
            end
            rsbc_pkg::ST_SCATTER: begin
                if (drained) begin
                    if (r_pass == rsbc_pkg::last_pass(r_cfg_passes)) begin
                        n_state = rsbc_pkg::ST_EMIT;
                    end else begin
                        n_state = rsbc_pkg::ST_COUNT;
                    end
                end
            end
            rsbc_pkg::ST_EMIT: begin
                if (!issue_more && !r_s1_valid) begin
                    n_state = rsbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rsbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rsbc_pkg::ST_IDLE;
            r_cfg_passes <= 3'd4;
            r_key_count  <= '0;
            r_overflow   <= 1'b0;
            r_src_sel    <= 1'b0;
            r_pass       <= '0;
            r_idx        <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_hidx       <= '0;
            r_p1_valid   <= 1'b0;
            r_offset     <= '0;
            o_strobe     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_cfg_passes <= i_cfg_data;
            end

            // Set loading and the return to an empty set after output.
            if (in_emit && (n_state == rsbc_pkg::ST_IDLE)) begin
                r_key_count <= '0;
                r_overflow  <= 1'b0;
            end else if (store_key) begin
                r_key_count <= r_key_count + CW'(1);
            end else if (accept) begin
                r_overflow <= 1'b1;
            end

            // The scattered buffer becomes the source at the end of a pass.
            if (in_scatter && (n_state != rsbc_pkg::ST_SCATTER)) begin
                r_src_sel <= !r_src_sel;
            end

            if (!busy) begin
                r_pass <= '0;
            end else if (in_scatter && (n_state == rsbc_pkg::ST_COUNT)) begin
                r_pass <= r_pass + 2'd1;
            end

            // Key read index restarts with every phase.
            if (n_state != r_state) begin
                r_idx <= '0;
            end else if (key_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            r_s1_valid <= key_issue;
            r_s2_valid <= r_s1_valid && (in_count || in_scatter);

            // Offset sweep over the histogram with a running total.
            if (!in_prefix) begin
                r_hidx   <= '0;
                r_offset <= '0;
            end else begin
                if (r_hidx != HIST_END) begin
                    r_hidx <= r_hidx + 9'd1;
                end
                if (r_p1_valid) begin
                    r_offset <= r_offset + hist_val;
                end
            end
            r_p1_valid <= in_prefix && (r_hidx != HIST_END);

            o_strobe <= in_emit && r_s1_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_last     <= (r_idx == (r_key_count - CW'(1)));
        r_s2_digit    <= s1_digit;
        r_s2_key      <= key_rdata;
        r_p1_addr     <= r_hidx[rsbc_pkg::DIGIT_W-1:0];
        o_sorted_key  <= key_rdata;
        o_last_result <= r_s1_last;
        o_overflow    <= r_overflow;
    end

endmodule

`default_nettype wire
